// File: rtl/core/mic_pkg.sv
// Package for the molecule image connect block: field widths, the atom and
// result beat types, register indexes and the per-axis wrap function.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package mic_pkg;

  localparam int COORD_BITS   = 32;
  localparam int MOL_ID_BITS  = 16;
  localparam int BOX_BITS     = 31;
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                          frame_start;
    logic [MOL_ID_BITS-1:0]        molecule_id;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
  } atom_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic signed [COORD_BITS-1:0]  out_z;
  } image_t;

  // Moves one coordinate into the image of its reference. The offset from
  // the reference is compared strictly against half the box (rounded down),
  // the box length is applied at most once, and the sum saturates.
  function automatic logic signed [COORD_BITS-1:0] connect_axis(
    input logic signed [COORD_BITS-1:0] pos,
    input logic signed [COORD_BITS-1:0] ref_pos,
    input logic        [BOX_BITS-1:0]   len
  );
    logic signed [COORD_BITS:0]   diff;
    logic signed [COORD_BITS:0]   half;
    logic signed [COORD_BITS+1:0] pos_w;
    logic signed [COORD_BITS+1:0] len_w;
    logic signed [COORD_BITS+1:0] sum;
    logic        [2:0]            top;
    diff  = (COORD_BITS+1)'(pos) - (COORD_BITS+1)'(ref_pos);
    half  = $signed((COORD_BITS+1)'(len >> 1));
    pos_w = (COORD_BITS+2)'(pos);
    len_w = $signed((COORD_BITS+2)'(len));
    if (diff > half) begin
      sum = pos_w - len_w;
    end else if (diff < -half) begin
      sum = pos_w + len_w;
    end else begin
      sum = pos_w;
    end
    top = sum[COORD_BITS+1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      return $signed(sum[COORD_BITS-1:0]);
    end else if (sum[COORD_BITS+1]) begin
      return $signed({1'b1, {(COORD_BITS-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(COORD_BITS-1){1'b1}}});
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/molecule_image_connect_top.sv
// Top level of the molecule image connect block: atom input register,
// reference state, per-axis wrap logic and the result register.
// Depends on mic_pkg for the beat types, widths and connect_axis.
`default_nettype none

// Puts the atoms of each molecule into one periodic image. One atom beat
// comes in on the atom channel and one result beat leaves on the image
// channel for every atom. An atom is a reference when it carries
// frame_start, when it is the first atom after reset, or when its molecule
// id differs from that of the atom before it; a reference is passed through
// unchanged and becomes the new origin. Every other atom has each
// coordinate's offset from the reference wrapped once by the box length
// when it lies strictly beyond half the box, and the result saturates to
// the signed coordinate range. The block takes one atom per clock cycle
// while the sink does not stall: an atom is captured in the input
// register, goes through one subtract, compare and add per axis, and lands
// in the result register, which drives the image channel. The input
// register keeps taking atoms while a finished result waits for the sink,
// and fills up only when the result register is held. Box lengths are
// written through the configuration port, which is always ready, and
// should change only while no atom is in flight.
module molecule_image_connect_top (
  input  wire                                   clk,
  input  wire                                   rst,
  // Atom channel.
  input  wire                                   atom_valid,
  output logic                                  atom_stall,
  input  mic_pkg::atom_t                        atom,
  // Result channel.
  output logic                                  image_valid,
  input  wire                                   image_stall,
  output mic_pkg::image_t                       image,
  // Configuration write channel.
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [mic_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire  [mic_pkg::BOX_BITS-1:0]          cfg_data
);
  import mic_pkg::*;

  // Box lengths, one per axis.
  logic [BOX_BITS-1:0] box_len_x;
  logic [BOX_BITS-1:0] box_len_y;
  logic [BOX_BITS-1:0] box_len_z;

  // Input register.
  logic  stage_valid;
  atom_t stage;

  // Reference state. Only have_ref is reset; the rest is written by the
  // first atom, which is always a reference.
  logic                          have_ref;
  logic [MOL_ID_BITS-1:0]        cur_mol;
  logic signed [COORD_BITS-1:0]  ref_x;
  logic signed [COORD_BITS-1:0]  ref_y;
  logic signed [COORD_BITS-1:0]  ref_z;

  logic   advance;
  logic   is_ref;
  image_t image_next;

  // Configuration writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_len_x <= '0;
      box_len_y <= '0;
      box_len_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_X: box_len_x <= cfg_data;
        REG_BOX_Y: box_len_y <= cfg_data;
        REG_BOX_Z: box_len_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is empty or
  // its beat is being taken this cycle.
  assign advance    = !image_valid || !image_stall;
  assign atom_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (atom_valid && !atom_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (atom_valid && !atom_stall) begin
      stage <= atom;
    end
  end

  // Reference detection and the wrap for non-reference atoms.
  assign is_ref = stage.frame_start || !have_ref || (stage.molecule_id != cur_mol);

  always_comb begin
    if (is_ref) begin
      image_next.out_x = stage.pos_x;
      image_next.out_y = stage.pos_y;
      image_next.out_z = stage.pos_z;
    end else begin
      image_next.out_x = connect_axis(stage.pos_x, ref_x, box_len_x);
      image_next.out_y = connect_axis(stage.pos_y, ref_y, box_len_y);
      image_next.out_z = connect_axis(stage.pos_z, ref_z, box_len_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_ref <= 1'b0;
    end else if (stage_valid && advance) begin
      have_ref <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance && is_ref) begin
      cur_mol <= stage.molecule_id;
      ref_x   <= stage.pos_x;
      ref_y   <= stage.pos_y;
      ref_z   <= stage.pos_z;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_valid <= 1'b0;
    end else if (advance) begin
      image_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      image <= image_next;
    end
  end

  // Reset leaves no reference, so the first atom is always a reference.
  a_no_ref_after_reset: assert property (@(posedge clk)
    rst |=> !have_ref)
    else $error("reference flag set right after reset");

  // Once an atom has been processed, a reference is held.
  a_ref_after_atom: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance |=> have_ref)
    else $error("no reference after a processed atom");

  // A reference atom comes out unchanged in the next cycle.
  a_ref_passthrough: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance && is_ref |=>
      image_valid && image.out_x == $past(stage.pos_x) &&
      image.out_y == $past(stage.pos_y) && image.out_z == $past(stage.pos_z))
    else $error("reference atom altered");

  // A held input register keeps its atom while the result is blocked.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("input register lost its atom while blocked");

  // The atom side is only held off when the input register is full.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    atom_stall |-> stage_valid && image_valid)
    else $error("atom channel stalled with room in the input register");

endmodule

`default_nettype wire
